### rtl/quaternion_arithmetic_unit_assert.svh
// ----------------------------------------------------------------------------
// quaternion arithmetic unit assertion macros
// clocked concurrent assertions, reset-qualified, reporting by $error
// ----------------------------------------------------------------------------
`ifndef QUATERNION_ARITHMETIC_UNIT_ASSERT_SVH
`define QUATERNION_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication
`define QAU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/qau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_pkg
// shared types and constants of the quaternion arithmetic unit
// ----------------------------------------------------------------------------
package qau_pkg;

  localparam int CW_DEFAULT = 16;
  localparam int FB_DEFAULT = 12;
  localparam int NUM_LANES  = 4;
  localparam int NUM_TERMS  = 4;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_NEG   = 3'd2,
    OP_SCALE = 3'd3,
    OP_HAM   = 3'd4
  } op_t;

  // component indexes
  localparam logic [1:0] IDX_X = 2'd0;
  localparam logic [1:0] IDX_Y = 2'd1;
  localparam logic [1:0] IDX_Z = 2'd2;
  localparam logic [1:0] IDX_W = 2'd3;

  // hamilton product operand routing, [lane][term]
  localparam logic [1:0] HAM_A_IDX [NUM_LANES][NUM_TERMS] = '{
    '{IDX_W, IDX_X, IDX_Y, IDX_Z},
    '{IDX_W, IDX_Y, IDX_Z, IDX_X},
    '{IDX_W, IDX_Z, IDX_X, IDX_Y},
    '{IDX_W, IDX_X, IDX_Y, IDX_Z}
  };
  localparam logic [1:0] HAM_B_IDX [NUM_LANES][NUM_TERMS] = '{
    '{IDX_X, IDX_W, IDX_Z, IDX_Y},
    '{IDX_Y, IDX_W, IDX_X, IDX_Z},
    '{IDX_Z, IDX_W, IDX_Y, IDX_X},
    '{IDX_W, IDX_X, IDX_Y, IDX_Z}
  };
  // bit k set: term k is subtracted
  localparam logic [NUM_TERMS-1:0] HAM_NEG [NUM_LANES] = '{
    4'b1000, 4'b1000, 4'b1000, 4'b1110
  };

  // pipeline advance enables handed to the lanes
  typedef struct packed {
    logic en1;
    logic en2;
  } qau_ctl_t;

endpackage

### rtl/qau_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_in_if
// operand channel: opcode, quaternions a and b, scale factor
// ----------------------------------------------------------------------------
interface qau_in_if import qau_pkg::*; #(
  parameter int COMPONENT_WIDTH = CW_DEFAULT
) ();
  logic                              valid;
  logic                              ready;
  logic [2:0]                        opcode;
  logic signed [COMPONENT_WIDTH-1:0] a_x;
  logic signed [COMPONENT_WIDTH-1:0] a_y;
  logic signed [COMPONENT_WIDTH-1:0] a_z;
  logic signed [COMPONENT_WIDTH-1:0] a_w;
  logic signed [COMPONENT_WIDTH-1:0] b_x;
  logic signed [COMPONENT_WIDTH-1:0] b_y;
  logic signed [COMPONENT_WIDTH-1:0] b_z;
  logic signed [COMPONENT_WIDTH-1:0] b_w;
  logic signed [COMPONENT_WIDTH-1:0] scale_factor;

  modport source (
    output valid, opcode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scale_factor,
    input  ready
  );
  modport sink (
    input  valid, opcode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scale_factor,
    output ready
  );
endinterface

### rtl/qau_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_out_if
// result channel: quaternion r and overflow flag
// ----------------------------------------------------------------------------
interface qau_out_if import qau_pkg::*; #(
  parameter int COMPONENT_WIDTH = CW_DEFAULT
) ();
  logic                              valid;
  logic                              ready;
  logic signed [COMPONENT_WIDTH-1:0] r_x;
  logic signed [COMPONENT_WIDTH-1:0] r_y;
  logic signed [COMPONENT_WIDTH-1:0] r_z;
  logic signed [COMPONENT_WIDTH-1:0] r_w;
  logic                              overflow;

  modport source (
    output valid, r_x, r_y, r_z, r_w, overflow,
    input  ready
  );
  modport sink (
    input  valid, r_x, r_y, r_z, r_w, overflow,
    output ready
  );
endinterface

### rtl/qau_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_lane
// one result component: four multipliers, signed sum, rounding, saturation
// ----------------------------------------------------------------------------
module qau_lane import qau_pkg::*; #(
  parameter int COMPONENT_WIDTH = CW_DEFAULT,
  parameter int FRACTION_BITS   = FB_DEFAULT
) (
  input  logic                              clk,
  input  qau_ctl_t                          ctl,
  input  op_t                               op,
  input  logic signed [COMPONENT_WIDTH-1:0] a_i,
  input  logic signed [COMPONENT_WIDTH-1:0] b_i,
  input  logic signed [COMPONENT_WIDTH-1:0] ma [NUM_TERMS],
  input  logic signed [COMPONENT_WIDTH-1:0] mb [NUM_TERMS],
  input  logic [NUM_TERMS-1:0]              neg_mask,
  output logic signed [COMPONENT_WIDTH-1:0] res,
  output logic                              ovf
);
  localparam int CW = COMPONENT_WIDTH;
  localparam int PW = 2 * CW;
  localparam int SW = PW + 2;

  localparam logic signed [SW-1:0] HALF = SW'(1) << (FRACTION_BITS - 1);
  localparam logic signed [SW-1:0] VMAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] VMIN = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  logic signed [PW-1:0] prod_r   [NUM_TERMS];
  logic signed [PW-1:0] prod_nxt [NUM_TERMS];
  logic signed [CW:0]   lin_r, lin_nxt;
  logic                 use_prod_r, use_prod_nxt;
  logic signed [SW-1:0] sum_r, sum_nxt;
  logic                 rnd_r;
  logic signed [SW-1:0] rounded;

  // stage 1: products and the linear ops
  always_comb begin
    for (int k = 0; k < NUM_TERMS; k++) begin
      prod_nxt[k] = PW'(ma[k]) * PW'(mb[k]);
    end
    lin_nxt      = '0;
    use_prod_nxt = 1'b0;
    case (op)
      OP_ADD:   lin_nxt = (CW+1)'(a_i) + (CW+1)'(b_i);
      OP_SUB:   lin_nxt = (CW+1)'(a_i) - (CW+1)'(b_i);
      OP_NEG:   lin_nxt = -((CW+1)'(a_i));
      OP_SCALE: use_prod_nxt = 1'b1;
      OP_HAM:   use_prod_nxt = 1'b1;
      default:  lin_nxt = '0;
    endcase
  end

  // stage 2: signed sum of the terms
  always_comb begin
    sum_nxt = SW'(lin_r);
    if (use_prod_r) begin
      sum_nxt = '0;
      for (int k = 0; k < NUM_TERMS; k++) begin
        if (neg_mask[k]) begin
          sum_nxt = sum_nxt - SW'(prod_r[k]);
        end else begin
          sum_nxt = sum_nxt + SW'(prod_r[k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      prod_r     <= prod_nxt;
      lin_r      <= lin_nxt;
      use_prod_r <= use_prod_nxt;
    end
    if (ctl.en2) begin
      sum_r <= sum_nxt;
      rnd_r <= use_prod_r;
    end
  end

  // products are rounded half up; every result is then clamped to the component range
  always_comb begin
    rounded = rnd_r ? ((sum_r + HALF) >>> FRACTION_BITS) : sum_r;
    ovf     = (rounded > VMAX) || (rounded < VMIN);
    if (rounded > VMAX) begin
      res = VMAX[CW-1:0];
    end else if (rounded < VMIN) begin
      res = VMIN[CW-1:0];
    end else begin
      res = rounded[CW-1:0];
    end
  end
endmodule

### rtl/qau_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_merge
// joins the lane results and overflow flags into the output register
// ----------------------------------------------------------------------------
module qau_merge import qau_pkg::*; #(
  parameter int COMPONENT_WIDTH = CW_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              v2,
  input  logic signed [COMPONENT_WIDTH-1:0] lane_res [NUM_LANES],
  input  logic [NUM_LANES-1:0]              lane_ovf,
  output logic                              en_o,
  qau_out_if.source                         out_if
);
  logic                              out_valid_r;
  logic signed [COMPONENT_WIDTH-1:0] res_r [NUM_LANES];
  logic                              ovf_r;

  assign en_o = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_o) begin
      out_valid_r <= v2;
    end
    if (en_o && v2) begin
      res_r <= lane_res;
      ovf_r <= |lane_ovf;
    end
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.r_x      = res_r[IDX_X];
  assign out_if.r_y      = res_r[IDX_Y];
  assign out_if.r_z      = res_r[IDX_Z];
  assign out_if.r_w      = res_r[IDX_W];
  assign out_if.overflow = ovf_r;
endmodule

### rtl/quaternion_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// saturating fixed point quaternion alu: add, subtract, negate, scale, product
// ----------------------------------------------------------------------------
// Takes one beat per cycle while in_if.ready is high and returns one result
// beat per input beat, in order. Each beat is registered after the operand
// multiply, after the term sum, and after round and clamp into the output
// register. Four lanes run side by side, one per
// result component (x, y, z, w); each lane owns four signed
// COMPONENT_WIDTH x COMPONENT_WIDTH multipliers, so the hamilton product
// needs all sixteen at once and scaling uses one per lane. Products are
// summed exactly, rounded once to nearest (ties upward) by FRACTION_BITS,
// and every component is clamped to the signed range; overflow is the OR of
// the four lane clamp flags. Opcodes 5 to 7 give a zero quaternion with no
// overflow. Each stage holds when the one after it is full and stalled, so
// in_if.ready only drops while the whole pipe is full and out_if.ready is low.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit import qau_pkg::*; #(
  parameter int COMPONENT_WIDTH = CW_DEFAULT,
  parameter int FRACTION_BITS   = FB_DEFAULT
) (
  input  logic      clk,
  input  logic      rst_n,
  qau_in_if.sink    in_if,
  qau_out_if.source out_if
);
  localparam int CW = COMPONENT_WIDTH;

  // pipe valid flags and advance enables
  logic     v1_r, v2_r;
  logic     en1, en2, en_o;
  qau_ctl_t ctl;

  // operands as arrays in component order
  logic signed [CW-1:0] a_q [NUM_LANES];
  logic signed [CW-1:0] b_q [NUM_LANES];
  op_t                  op;

  // lane outputs into the merge stage
  logic signed [CW-1:0] lane_res [NUM_LANES];
  logic [NUM_LANES-1:0] lane_ovf;

  assign op       = op_t'(in_if.opcode);
  assign a_q[IDX_X] = in_if.a_x;
  assign a_q[IDX_Y] = in_if.a_y;
  assign a_q[IDX_Z] = in_if.a_z;
  assign a_q[IDX_W] = in_if.a_w;
  assign b_q[IDX_X] = in_if.b_x;
  assign b_q[IDX_Y] = in_if.b_y;
  assign b_q[IDX_Z] = in_if.b_z;
  assign b_q[IDX_W] = in_if.b_w;

  // a stage advances when it is empty or the next stage advances
  assign en2         = !v2_r || en_o;
  assign en1         = !v1_r || en2;
  assign ctl.en1     = en1;
  assign ctl.en2     = en2;
  assign in_if.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_if.valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    logic signed [CW-1:0] ma [NUM_TERMS];
    logic signed [CW-1:0] mb [NUM_TERMS];

    // multiplier operand routing: scale uses term 0, product uses all four
    always_comb begin
      for (int k = 0; k < NUM_TERMS; k++) begin
        ma[k] = '0;
        mb[k] = '0;
      end
      case (op)
        OP_SCALE: begin
          ma[0] = in_if.scale_factor;
          mb[0] = a_q[g];
        end
        OP_HAM: begin
          for (int k = 0; k < NUM_TERMS; k++) begin
            ma[k] = a_q[HAM_A_IDX[g][k]];
            mb[k] = b_q[HAM_B_IDX[g][k]];
          end
        end
        default: begin
          ma[0] = '0;
        end
      endcase
    end

    qau_lane #(
      .COMPONENT_WIDTH (COMPONENT_WIDTH),
      .FRACTION_BITS   (FRACTION_BITS)
    ) u_lane (
      .clk      (clk),
      .ctl      (ctl),
      .op       (op),
      .a_i      (a_q[g]),
      .b_i      (b_q[g]),
      .ma       (ma),
      .mb       (mb),
      .neg_mask (HAM_NEG[g]),
      .res      (lane_res[g]),
      .ovf      (lane_ovf[g])
    );
  end

  // output register and overflow merge
  qau_merge #(
    .COMPONENT_WIDTH (COMPONENT_WIDTH)
  ) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .v2       (v2_r),
    .lane_res (lane_res),
    .lane_ovf (lane_ovf),
    .en_o     (en_o),
    .out_if   (out_if)
  );
endmodule

### rtl/qau_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_checker
// port-level checks of the quaternion arithmetic unit, bound to the top
// ----------------------------------------------------------------------------
`include "quaternion_arithmetic_unit_assert.svh"

module qau_checker import qau_pkg::*; #(
  parameter int COMPONENT_WIDTH = CW_DEFAULT
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [COMPONENT_WIDTH-1:0] out_r_x,
  input logic signed [COMPONENT_WIDTH-1:0] out_r_y,
  input logic signed [COMPONENT_WIDTH-1:0] out_r_z,
  input logic signed [COMPONENT_WIDTH-1:0] out_r_w,
  input logic                              out_overflow
);
  localparam logic [COMPONENT_WIDTH-1:0] CMAX = {1'b0, {(COMPONENT_WIDTH-1){1'b1}}};
  localparam logic [COMPONENT_WIDTH-1:0] CMIN = {1'b1, {(COMPONENT_WIDTH-1){1'b0}}};

  logic in_beat, x_edge, y_edge, z_edge, w_edge, lim_hit;

  assign in_beat = in_valid && in_ready;
  assign x_edge  = (out_r_x == CMAX) || (out_r_x == CMIN);
  assign y_edge  = (out_r_y == CMAX) || (out_r_y == CMIN);
  assign z_edge  = (out_r_z == CMAX) || (out_r_z == CMIN);
  assign w_edge  = (out_r_w == CMAX) || (out_r_w == CMIN);
  assign lim_hit = x_edge || y_edge || z_edge || w_edge;

  // a stalled result beat stays offered
  `QAU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")
  // with no result waiting the pipe must take input
  `QAU_ASSERT_SAME(a_in_free, !out_valid, in_ready, "input stalled with empty output")
  // an accepted beat reaches the output while the result side keeps taking beats
  `QAU_ASSERT_NEXT(a_latency, in_beat ##1 out_ready ##1 out_ready, out_valid, "result late")
  // a clamped result shows at least one component at a range limit
  `QAU_ASSERT_SAME(a_ovf_limit, out_valid && out_overflow, lim_hit, "overflow without clamp")
endmodule

bind quaternion_arithmetic_unit qau_checker #(
  .COMPONENT_WIDTH (COMPONENT_WIDTH)
) u_qau_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_r_x      (out_if.r_x),
  .out_r_y      (out_if.r_y),
  .out_r_z      (out_if.r_z),
  .out_r_w      (out_if.r_w),
  .out_overflow (out_if.overflow)
);
